/* hdl/cpt_pkg.sv */
// ---------------------------------------------------------------------------
// cpt_pkg: shared types and constants
// Region kind, control word carried from the classifier to the solver,
// sizing constants of the arithmetic units and depth of the job queue.
// ---------------------------------------------------------------------------
package cpt_pkg;

  // multiplier digit size: one DIGIT_W slice of operand b per stage
  localparam int DIGIT_W   = 8;
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);

  typedef enum logic [1:0] {
    KIND_CORNER,
    KIND_EDGE,
    KIND_FACE
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  den_pos;
  } ctl_t;

endpackage

/* hdl/cpt_mul.sv */
// ---------------------------------------------------------------------------
// cpt_mul: pipelined signed multiplier
// Exact a * b. Operand b is consumed one digit per stage.
// All stages advance together on en.
// ---------------------------------------------------------------------------
module cpt_mul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import cpt_pkg::*;

  localparam int NS = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BX = NS * DIGIT_W;
  localparam int PW = AW + BX;

  logic signed [AW-1:0] a_r   [NS];
  logic signed [BX-1:0] b_r   [NS];
  logic signed [PW-1:0] acc_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [AW-1:0]        a_in;
    logic signed [BX-1:0]        b_in;
    logic signed [PW-1:0]        acc_in;
    logic signed [DIGIT_W:0]     dig;
    logic signed [AW+DIGIT_W:0]  pp;

    if (i == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[i-1];
      assign b_in   = b_r[i-1];
      assign acc_in = acc_r[i-1];
    end

    // top digit carries the sign, lower digits are plain magnitudes
    if (i == NS - 1) begin : g_top
      assign dig = {b_in[BX-1], b_in[i*DIGIT_W +: DIGIT_W]};
    end else begin : g_low
      assign dig = {1'b0, b_in[i*DIGIT_W +: DIGIT_W]};
    end

    assign pp = a_in * dig;

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i]   <= a_in;
        b_r[i]   <= b_in;
        acc_r[i] <= acc_in + (PW'(pp) <<< (i * DIGIT_W));
      end
    end
  end

  assign p = acc_r[NS-1][AW+BW-1:0];

endmodule

/* hdl/cpt_div.sv */
// ---------------------------------------------------------------------------
// cpt_div: pipelined restoring divider
// floor(u / d) over QB quotient bits, one bit per stage, plus a flag that
// the quotient does not fit in QB bits.
// ---------------------------------------------------------------------------
module cpt_div #(
  parameter int UW = 172,
  parameter int DW = 139,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [UW-1:0] u,
  input  logic [DW-1:0] d,
  output logic [QB-1:0] q,
  output logic          ovf
);

  localparam int RW = ((UW > DW + QB) ? UW : DW + QB) + 1;

  logic [RW-1:0] rem_r [QB+1];
  logic [DW-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          ovf_r [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(u);
      d_r[0]   <= d;
      q_r[0]   <= '0;
      ovf_r[0] <= RW'(u) >= (RW'(d) << QB);
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_bit
    localparam int SH = QB - i;
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(d_r[i-1]) << SH;
    assign ge = rem_r[i-1] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rem_r[i-1] - sh) : rem_r[i-1];
        q_r[i]   <= q_r[i-1] | (ge ? (QB'(1) << SH) : '0);
        d_r[i]   <= d_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign ovf = ovf_r[QB];

endmodule

/* hdl/cpt_front.sv */
// ---------------------------------------------------------------------------
// cpt_front: region classifier
// Forms edge and offset vectors, the six dot products and three cross
// terms, picks the region and builds the solve job for the back end.
// ---------------------------------------------------------------------------
module cpt_front #(
  parameter  int CW   = 32,
  localparam int EW   = CW + 1,
  localparam int DOTW = 2 * CW + 4,
  localparam int CRW  = 2 * DOTW + 1,
  localparam int DENW = CRW + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [CW-1:0]   pin [3],
  input  logic signed [CW-1:0]   ain [3],
  input  logic signed [CW-1:0]   bin [3],
  input  logic signed [CW-1:0]   cin [3],
  output logic                   out_vld,
  output logic signed [CW-1:0]   st  [3],
  output logic signed [EW-1:0]   xv  [3],
  output logic signed [EW-1:0]   yv  [3],
  output logic signed [CRW-1:0]  pv,
  output logic signed [CRW-1:0]  qv,
  output logic signed [DENW-1:0] dv,
  output cpt_pkg::ctl_t          ctl
);
  import cpt_pkg::*;

  localparam int NS   = (DOTW + DIGIT_W - 1) / DIGIT_W;
  localparam int FL   = NS + 6;
  localparam int MW   = 2 * DOTW;
  localparam int DIFW = DOTW + 1;

  logic [FL-1:0] vld_r;

  logic signed [CW-1:0]   p0_r [3], a0_r [3], b0_r [3], c0_r [3];
  logic signed [EW-1:0]   ab1_r [3], ac1_r [3], bc1_r [3];
  logic signed [EW-1:0]   ap1_r [3], bp1_r [3], cp1_r [3];
  logic signed [CW-1:0]   a1_r [3], b1_r [3], c1_r [3];
  logic signed [2*EW-1:0] pr2_r [6][3];
  logic signed [EW-1:0]   ab2_r [3], ac2_r [3], bc2_r [3];
  logic signed [CW-1:0]   a2_r [3], b2_r [3], c2_r [3];
  logic signed [DOTW-1:0] d3_r [6];
  logic signed [EW-1:0]   ab3_r [3], ac3_r [3], bc3_r [3];
  logic signed [CW-1:0]   a3_r [3], b3_r [3], c3_r [3];

  logic signed [DOTW-1:0] sd_r  [NS][6];
  logic signed [EW-1:0]   sab_r [NS][3], sac_r [NS][3], sbc_r [NS][3];
  logic signed [CW-1:0]   sa_r  [NS][3], sb_r [NS][3], sc_r [NS][3];

  logic signed [MW-1:0]   m [6];

  logic signed [CRW-1:0]  va_r, vb_r, vc_r;
  logic signed [DOTW-1:0] d_r [6];
  logic signed [EW-1:0]   ab_r [3], ac_r [3], bc_r [3];
  logic signed [CW-1:0]   a_r [3], b_r [3], c_r [3];

  logic signed [CW-1:0]   st_nxt [3];
  logic signed [EW-1:0]   x_nxt [3], y_nxt [3];
  logic signed [CRW-1:0]  p_nxt, q_nxt;
  logic signed [DENW-1:0] den_nxt;
  kind_t                  kind_nxt;
  logic signed [DIFW-1:0] d43, d56, e1den, e2den;
  logic signed [DIFW:0]   e3den;
  logic signed [DENW-1:0] fden;

  logic signed [CW-1:0]   st_r [3];
  logic signed [EW-1:0]   x_r [3], y_r [3];
  logic signed [CRW-1:0]  p_r, q_r;
  logic signed [DENW-1:0] den_r;
  ctl_t                   ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FL-2:0], in_vld};
    end
  end

  // input, differences, products, dot products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[k]  <= pin[k];
        a0_r[k]  <= ain[k];
        b0_r[k]  <= bin[k];
        c0_r[k]  <= cin[k];
        ab1_r[k] <= EW'(b0_r[k]) - EW'(a0_r[k]);
        ac1_r[k] <= EW'(c0_r[k]) - EW'(a0_r[k]);
        bc1_r[k] <= EW'(c0_r[k]) - EW'(b0_r[k]);
        ap1_r[k] <= EW'(p0_r[k]) - EW'(a0_r[k]);
        bp1_r[k] <= EW'(p0_r[k]) - EW'(b0_r[k]);
        cp1_r[k] <= EW'(p0_r[k]) - EW'(c0_r[k]);
        a1_r[k]  <= a0_r[k];
        b1_r[k]  <= b0_r[k];
        c1_r[k]  <= c0_r[k];
        pr2_r[0][k] <= ab1_r[k] * ap1_r[k];
        pr2_r[1][k] <= ac1_r[k] * ap1_r[k];
        pr2_r[2][k] <= ab1_r[k] * bp1_r[k];
        pr2_r[3][k] <= ac1_r[k] * bp1_r[k];
        pr2_r[4][k] <= ab1_r[k] * cp1_r[k];
        pr2_r[5][k] <= ac1_r[k] * cp1_r[k];
        ab2_r[k] <= ab1_r[k];
        ac2_r[k] <= ac1_r[k];
        bc2_r[k] <= bc1_r[k];
        a2_r[k]  <= a1_r[k];
        b2_r[k]  <= b1_r[k];
        c2_r[k]  <= c1_r[k];
        ab3_r[k] <= ab2_r[k];
        ac3_r[k] <= ac2_r[k];
        bc3_r[k] <= bc2_r[k];
        a3_r[k]  <= a2_r[k];
        b3_r[k]  <= b2_r[k];
        c3_r[k]  <= c2_r[k];
      end
      for (int j = 0; j < 6; j++) begin
        d3_r[j] <= DOTW'(pr2_r[j][0]) + DOTW'(pr2_r[j][1]) + DOTW'(pr2_r[j][2]);
      end
    end
  end

  // cross products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m0 (.clk, .en, .a(d3_r[0]), .b(d3_r[3]), .p(m[0]));
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m1 (.clk, .en, .a(d3_r[2]), .b(d3_r[1]), .p(m[1]));
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m2 (.clk, .en, .a(d3_r[4]), .b(d3_r[1]), .p(m[2]));
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m3 (.clk, .en, .a(d3_r[0]), .b(d3_r[5]), .p(m[3]));
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m4 (.clk, .en, .a(d3_r[2]), .b(d3_r[5]), .p(m[4]));
  cpt_mul #(.AW(DOTW), .BW(DOTW)) u_m5 (.clk, .en, .a(d3_r[4]), .b(d3_r[3]), .p(m[5]));

  // carry the rest of the item alongside the multipliers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        for (int j = 0; j < 6; j++) begin
          sd_r[s][j] <= (s == 0) ? d3_r[j] : sd_r[s-1][j];
        end
        for (int k = 0; k < 3; k++) begin
          sab_r[s][k] <= (s == 0) ? ab3_r[k] : sab_r[s-1][k];
          sac_r[s][k] <= (s == 0) ? ac3_r[k] : sac_r[s-1][k];
          sbc_r[s][k] <= (s == 0) ? bc3_r[k] : sbc_r[s-1][k];
          sa_r[s][k]  <= (s == 0) ? a3_r[k]  : sa_r[s-1][k];
          sb_r[s][k]  <= (s == 0) ? b3_r[k]  : sb_r[s-1][k];
          sc_r[s][k]  <= (s == 0) ? c3_r[k]  : sc_r[s-1][k];
        end
      end
      vc_r <= CRW'(m[0]) - CRW'(m[1]);
      vb_r <= CRW'(m[2]) - CRW'(m[3]);
      va_r <= CRW'(m[4]) - CRW'(m[5]);
      for (int j = 0; j < 6; j++) begin
        d_r[j] <= sd_r[NS-1][j];
      end
      for (int k = 0; k < 3; k++) begin
        ab_r[k] <= sab_r[NS-1][k];
        ac_r[k] <= sac_r[NS-1][k];
        bc_r[k] <= sbc_r[NS-1][k];
        a_r[k]  <= sa_r[NS-1][k];
        b_r[k]  <= sb_r[NS-1][k];
        c_r[k]  <= sc_r[NS-1][k];
      end
    end
  end

  // region pick; test order matters
  always_comb begin
    d43   = DIFW'(d_r[3]) - DIFW'(d_r[2]);
    d56   = DIFW'(d_r[4]) - DIFW'(d_r[5]);
    e1den = DIFW'(d_r[0]) - DIFW'(d_r[2]);
    e2den = DIFW'(d_r[1]) - DIFW'(d_r[5]);
    e3den = (DIFW + 1)'(d43) + (DIFW + 1)'(d56);
    fden  = DENW'(va_r) + DENW'(vb_r) + DENW'(vc_r);
    kind_nxt = KIND_CORNER;
    p_nxt    = '0;
    q_nxt    = '0;
    den_nxt  = '0;
    for (int k = 0; k < 3; k++) begin
      st_nxt[k] = a_r[k];
      x_nxt[k]  = '0;
      y_nxt[k]  = '0;
    end
    priority if (d_r[0] <= 0 && d_r[1] <= 0) begin
      kind_nxt = KIND_CORNER;
    end else if (d_r[2] >= 0 && d43 <= 0) begin
      kind_nxt = KIND_CORNER;
      st_nxt   = b_r;
    end else if (vc_r <= 0 && d_r[0] >= 0 && d_r[2] <= 0) begin
      kind_nxt = KIND_EDGE;
      x_nxt    = ab_r;
      p_nxt    = CRW'(d_r[0]);
      den_nxt  = DENW'(e1den);
    end else if (d_r[5] >= 0 && d56 <= 0) begin
      kind_nxt = KIND_CORNER;
      st_nxt   = c_r;
    end else if (vb_r <= 0 && d_r[1] >= 0 && d_r[5] <= 0) begin
      kind_nxt = KIND_EDGE;
      x_nxt    = ac_r;
      p_nxt    = CRW'(d_r[1]);
      den_nxt  = DENW'(e2den);
    end else if (va_r <= 0 && d43 >= 0 && d56 >= 0) begin
      kind_nxt = KIND_EDGE;
      st_nxt   = b_r;
      x_nxt    = bc_r;
      p_nxt    = CRW'(d43);
      den_nxt  = DENW'(e3den);
    end else begin
      kind_nxt = KIND_FACE;
      x_nxt    = ab_r;
      y_nxt    = ac_r;
      p_nxt    = vb_r;
      q_nxt    = vc_r;
      den_nxt  = fden;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r          <= st_nxt;
      x_r           <= x_nxt;
      y_r           <= y_nxt;
      p_r           <= p_nxt;
      q_r           <= q_nxt;
      den_r         <= den_nxt;
      ctl_r.kind    <= kind_nxt;
      ctl_r.den_pos <= den_nxt > 0;
    end
  end

  assign out_vld = vld_r[FL-1];
  assign st      = st_r;
  assign xv      = x_r;
  assign yv      = y_r;
  assign pv      = p_r;
  assign qv      = q_r;
  assign dv      = den_r;
  assign ctl     = ctl_r;

endmodule

/* hdl/cpt_back.sv */
// ---------------------------------------------------------------------------
// cpt_back: nearest point solver
// Forms the per-axis numerators, divides with round to nearest (ties away
// from zero), adds the start corner and saturates.
// ---------------------------------------------------------------------------
module cpt_back #(
  parameter  int CW   = 32,
  localparam int EW   = CW + 1,
  localparam int DOTW = 2 * CW + 4,
  localparam int CRW  = 2 * DOTW + 1,
  localparam int DENW = CRW + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [CW-1:0]   st  [3],
  input  logic signed [EW-1:0]   xv  [3],
  input  logic signed [EW-1:0]   yv  [3],
  input  logic signed [CRW-1:0]  pv,
  input  logic signed [CRW-1:0]  qv,
  input  logic signed [DENW-1:0] dv,
  input  cpt_pkg::ctl_t          ctl,
  output logic                   out_vld,
  output logic signed [CW-1:0]   nearest [3]
);
  import cpt_pkg::*;

  localparam int NS  = (EW + DIGIT_W - 1) / DIGIT_W;
  localparam int PRW = CRW + EW;
  localparam int NW  = PRW + 1;
  localparam int UW  = NW + 2;
  localparam int QB  = CW + 1;
  localparam int DL  = QB + 1;
  localparam int RSW = CW + 3;
  localparam int BL  = NS + QB + 5;

  logic [BL-1:0] vld_r;

  logic signed [CW-1:0]   st0_r [3];
  logic signed [EW-1:0]   x0_r [3], y0_r [3];
  logic signed [CRW-1:0]  p0_r, q0_r;
  logic signed [DENW-1:0] den0_r;
  ctl_t                   ctl0_r;

  logic signed [PRW-1:0]  mx [3], my [3];
  logic signed [CW-1:0]   sst_r [NS][3];
  logic signed [DENW-1:0] sden_r [NS];
  ctl_t                   sctl_r [NS];

  logic signed [NW-1:0]   n6_r [3];
  logic signed [CW-1:0]   st6_r [3];
  logic signed [DENW-1:0] den6_r;
  ctl_t                   ctl6_r;

  logic [NW-1:0]          mag [3];
  logic [UW-1:0]          u7_r [3];
  logic [DENW-1:0]        d27_r;
  logic                   neg7_r [3];
  logic signed [CW-1:0]   st7_r [3];
  logic                   use7_r;

  logic [QB-1:0]          qd [3];
  logic                   ovf [3];
  logic signed [CW-1:0]   tst_r [DL][3];
  logic                   tneg_r [DL][3];
  logic                   tuse_r [DL];

  logic signed [RSW-1:0]  qs [3], rs [3];
  logic signed [CW-1:0]   res_nxt [3];
  logic signed [CW-1:0]   out_r [3];

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BL-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r  <= st;
      x0_r   <= xv;
      y0_r   <= yv;
      p0_r   <= pv;
      q0_r   <= qv;
      den0_r <= dv;
      ctl0_r <= ctl;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cpt_mul #(.AW(CRW), .BW(EW)) u_mx (
      .clk, .en, .a(p0_r), .b(x0_r[k]), .p(mx[k])
    );
    cpt_mul #(.AW(CRW), .BW(EW)) u_my (
      .clk, .en, .a(q0_r), .b(y0_r[k]), .p(my[k])
    );
    cpt_div #(.UW(UW), .DW(DENW), .QB(QB)) u_div (
      .clk, .en, .u(u7_r[k]), .d(d27_r), .q(qd[k]), .ovf(ovf[k])
    );
  end

  // numerators, then round-to-nearest prep: (2|n| + den) / (2 den)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = n6_r[k][NW-1] ? NW'(-n6_r[k]) : NW'(n6_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        if (s == 0) begin
          sst_r[s]  <= st0_r;
          sden_r[s] <= den0_r;
          sctl_r[s] <= ctl0_r;
        end else begin
          sst_r[s]  <= sst_r[s-1];
          sden_r[s] <= sden_r[s-1];
          sctl_r[s] <= sctl_r[s-1];
        end
      end
      for (int k = 0; k < 3; k++) begin
        n6_r[k]   <= NW'(mx[k]) + NW'(my[k]);
        u7_r[k]   <= (UW'(mag[k]) << 1) + UW'($unsigned(den6_r));
        neg7_r[k] <= n6_r[k][NW-1];
      end
      st6_r  <= sst_r[NS-1];
      den6_r <= sden_r[NS-1];
      ctl6_r <= sctl_r[NS-1];
      d27_r  <= {den6_r[DENW-2:0], 1'b0};
      st7_r  <= st6_r;
      use7_r <= (ctl6_r.kind == KIND_CORNER) || !ctl6_r.den_pos;
      for (int s = 0; s < DL; s++) begin
        if (s == 0) begin
          tst_r[s]  <= st7_r;
          tneg_r[s] <= neg7_r;
          tuse_r[s] <= use7_r;
        end else begin
          tst_r[s]  <= tst_r[s-1];
          tneg_r[s] <= tneg_r[s-1];
          tuse_r[s] <= tuse_r[s-1];
        end
      end
      out_r <= res_nxt;
    end
  end

  // apply sign, add start, clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = tneg_r[DL-1][k] ? -$signed(RSW'(qd[k])) : $signed(RSW'(qd[k]));
      rs[k] = RSW'(tst_r[DL-1][k]) + qs[k];
      if (tuse_r[DL-1]) begin
        res_nxt[k] = tst_r[DL-1][k];
      end else if (ovf[k]) begin
        res_nxt[k] = tneg_r[DL-1][k] ? SAT_MIN : SAT_MAX;
      end else if (rs[k][RSW-1:CW-1] != {(RSW-CW+1){rs[k][RSW-1]}}) begin
        res_nxt[k] = rs[k][RSW-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res_nxt[k] = rs[k][CW-1:0];
      end
    end
  end

  assign out_vld = vld_r[BL-1];
  assign nearest = out_r;

endmodule

/* hdl/closest_point_on_triangle_unit.sv */
// ---------------------------------------------------------------------------
// closest_point_on_triangle_unit: nearest point on a 3D triangle
// Classifier front end, short job queue, solver back end.
//
//   channel | handshake            | beat
//   --------+----------------------+-------------------------------------
//   input   | push / full          | query point and corners a, b, c
//   result  | pop / empty          | nearest point x, y, z
//
// One beat per cycle sustained while results are popped. An accepted beat
// passes through the front (dot and cross product multipliers), the job
// queue, and the back with its one-bit-per-stage dividers.
// Synchronous reset clears valid bits, queue pointers and queue count only.
// A held result stalls the back end; the front keeps accepting until the
// four-entry job queue fills, then full rises.
// ---------------------------------------------------------------------------
module closest_point_on_triangle_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_z,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] out_nearest_x,
  output logic signed [COORD_WIDTH-1:0] out_nearest_y,
  output logic signed [COORD_WIDTH-1:0] out_nearest_z
);
  import cpt_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int DOTW = 2 * CW + 4;
  localparam int CRW  = 2 * DOTW + 1;
  localparam int DENW = CRW + 2;
  localparam int QW   = 3 * CW + 6 * EW + 2 * CRW + DENW + $bits(ctl_t);

  logic                   en_f, en_b;
  logic                   f_vld, b_vld;
  logic signed [CW-1:0]   f_st [3], h_st [3];
  logic signed [EW-1:0]   f_x [3], f_y [3], h_x [3], h_y [3];
  logic signed [CRW-1:0]  f_p, f_q, h_p, h_q;
  logic signed [DENW-1:0] f_den, h_den;
  ctl_t                   f_ctl, h_ctl;
  logic signed [CW-1:0]   pin [3], ain [3], bin [3], cin [3];
  logic signed [CW-1:0]   nearest [3];

  logic [QW-1:0]       mid_mem [MID_DEPTH];
  logic [MID_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [MID_AW:0]     cnt_r;
  logic                mid_full, mid_push, mid_pop;

  assign pin = '{in_query_x, in_query_y, in_query_z};
  assign ain = '{in_corner_a_x, in_corner_a_y, in_corner_a_z};
  assign bin = '{in_corner_b_x, in_corner_b_y, in_corner_b_z};
  assign cin = '{in_corner_c_x, in_corner_c_y, in_corner_c_z};

  // front holds only when its finished job has nowhere to go
  assign mid_full = cnt_r == (MID_AW + 1)'(MID_DEPTH);
  assign en_f     = !(f_vld && mid_full);
  assign mid_push = f_vld && en_f;
  assign en_b     = !b_vld || pop;
  assign mid_pop  = en_b && (cnt_r != '0);

  cpt_front #(.CW(CW)) u_front (
    .clk, .rst_n, .en(en_f), .in_vld(push),
    .pin, .ain, .bin, .cin,
    .out_vld(f_vld), .st(f_st), .xv(f_x), .yv(f_y),
    .pv(f_p), .qv(f_q), .dv(f_den), .ctl(f_ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (mid_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (mid_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (MID_AW + 1)'(mid_push) - (MID_AW + 1)'(mid_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (mid_push) begin
      mid_mem[wr_ptr_r] <= {f_ctl, f_den, f_q, f_p, f_y[2], f_y[1], f_y[0],
                            f_x[2], f_x[1], f_x[0], f_st[2], f_st[1], f_st[0]};
    end
  end

  assign {h_ctl, h_den, h_q, h_p, h_y[2], h_y[1], h_y[0],
          h_x[2], h_x[1], h_x[0], h_st[2], h_st[1], h_st[0]} = mid_mem[rd_ptr_r];

  cpt_back #(.CW(CW)) u_back (
    .clk, .rst_n, .en(en_b), .in_vld(cnt_r != '0),
    .st(h_st), .xv(h_x), .yv(h_y), .pv(h_p), .qv(h_q), .dv(h_den), .ctl(h_ctl),
    .out_vld(b_vld), .nearest
  );

  assign full          = !en_f;
  assign empty         = !b_vld;
  assign out_nearest_x = nearest[0];
  assign out_nearest_y = nearest[1];
  assign out_nearest_z = nearest[2];

endmodule

/* hdl/cpt_checker.sv */
// ---------------------------------------------------------------------------
// cpt_checker: port-level checks for the nearest point unit
// Tracks beats in flight and checks reset, hold and occupancy behavior.
// ---------------------------------------------------------------------------
module cpt_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic signed [COORD_WIDTH-1:0] out_nearest_x,
  input logic signed [COORD_WIDTH-1:0] out_nearest_y,
  input logic signed [COORD_WIDTH-1:0] out_nearest_z
);

  logic [7:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_nearest_x) &&
                       $stable(out_nearest_y) && $stable(out_nearest_z))
    else $error("held result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> cnt_r != 8'd0)
    else $error("result shown with no beat in flight");

  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> cnt_r != 8'd0)
    else $error("full with nothing in flight");

endmodule

bind closest_point_on_triangle_unit cpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
  .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_nearest_x(out_nearest_x), .out_nearest_y(out_nearest_y),
  .out_nearest_z(out_nearest_z)
);
